// File: sv/ultrasonic_echo_ranger_assert.svh
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define UER_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define UER_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Types, register codes and constants shared by the echo ranger modules.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int LineW     = 5;
  localparam int SelW      = 3;
  localparam int CntW      = 16;
  localparam int DistW     = 11;
  localparam int TrigW     = 8;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;
  localparam int ProdW     = 31;
  localparam int DistShift = 20;

  localparam int NumSensorsDef = 5;

  localparam logic [14:0]      DistMul  = 15'd17826;
  localparam logic [ProdW-1:0] DistHalf = ProdW'(524288);

  localparam logic [TrigW-1:0] TrigTicksRst  = 8'd10;
  localparam logic [CntW-1:0]  RiseTimeRst   = 16'd30000;
  localparam logic [CntW-1:0]  HighTimeRst   = 16'd60000;
  localparam logic [DistW-1:0] MaxDistRst    = 11'd600;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTriggerTicks = 2'd0,
    CfgRiseTimeout  = 2'd1,
    CfgHighTimeout  = 2'd2,
    CfgMaxDistance  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNoRise  = 2'd1,
    StTooLong = 2'd2,
    StRange   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    PhIdle = 4'b0001,
    PhTrig = 4'b0010,
    PhRise = 4'b0100,
    PhHigh = 4'b1000
  } phase_e;

  typedef struct packed {
    logic             start_req;
    logic [SelW-1:0]  sensor_sel;
    logic [LineW-1:0] echo_lines;
  } in_req_t;

  typedef struct packed {
    logic [LineW-1:0] trigger_lines;
    logic             busy_res;
    logic             done_res;
    logic [SelW-1:0]  sensor_out;
    logic [DistW-1:0] distance_cm;
    logic [1:0]       status;
  } out_req_t;

  typedef struct packed {
    logic [TrigW-1:0] trigger_ticks;
    logic [CntW-1:0]  rise_timeout;
    logic [CntW-1:0]  high_timeout;
    logic [DistW-1:0] max_distance;
  } cfg_t;

endpackage

// File: sv/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Pulse-echo range measurement over up to five trigger/echo sensor pairs.
// ----------------------------------------------------------------------------
// Usage: present one request per 1 us tick on the input channel (in_valid_i,
// in_stall_o, in_req_i) carrying start_req, sensor_sel and the sampled echo
// lines. Every accepted request yields exactly one result request on the
// output channel (out_valid_o, out_stall_i, out_req_o) with the trigger
// drive, busy flag and, on the finishing tick, sensor, distance and status.
// Throughput is one request per cycle unless the receiver stalls; the
// echo_count to centimetre multiply and the phase update sit between the
// input and result registers. When the receiver stalls, the result register
// holds its request and the input register fills; the input side stalls
// only while both are full. Configuration registers (trigger_ticks,
// rise_timeout, high_timeout, max_distance) are written through cfg_we_i/
// cfg_idx_i/cfg_wdata_i; the user must do so only while the block is idle,
// which the block does not enforce. Reset clears both valid flags, returns
// the sequencer to idle and loads the register defaults.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger import uer_pkg::*; #(
  parameter int NumSensors = NumSensorsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_req_t             in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_req_t            out_req_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic     in_valid_q;
  in_req_t  in_req_q;
  logic     out_valid_q;
  out_req_t out_req_q;
  logic     advance;
  logic     step;
  cfg_t     cfg;
  out_req_t res;

  // Result register free or draining this cycle
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  uer_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  uer_seq #(
    .NumSensors (NumSensors)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (in_req_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Input register: load whenever the input side is not stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_req_q <= in_req_i;
    end
  end

  // Result register: hold while stalled, advance otherwise
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_req_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

// File: sv/uer_cfg_regs.sv
// ----------------------------------------------------------------------------
// uer_cfg_regs
// Configuration register file written through a plain indexed write port.
// ----------------------------------------------------------------------------
module uer_cfg_regs import uer_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgTriggerTicks: cfg_d.trigger_ticks = cfg_wdata_i[TrigW-1:0];
        CfgRiseTimeout:  cfg_d.rise_timeout  = cfg_wdata_i[CntW-1:0];
        CfgHighTimeout:  cfg_d.high_timeout  = cfg_wdata_i[CntW-1:0];
        CfgMaxDistance:  cfg_d.max_distance  = cfg_wdata_i[DistW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_ticks <= TrigTicksRst;
      cfg_q.rise_timeout  <= RiseTimeRst;
      cfg_q.high_timeout  <= HighTimeRst;
      cfg_q.max_distance  <= MaxDistRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/uer_dist.sv
// ----------------------------------------------------------------------------
// uer_dist
// Echo tick count to centimetres, round(ticks * 0.017), with range check.
// ----------------------------------------------------------------------------
module uer_dist import uer_pkg::*; (
  input  logic [CntW-1:0]  ticks_i,
  input  logic [DistW-1:0] max_dist_i,
  output logic [DistW-1:0] dist_o,
  output logic             out_of_range_o
);

  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] sum;

  // Q0.20 factor, round half up; the top bits never exceed 1114
  assign prod           = ProdW'(ticks_i) * ProdW'(DistMul);
  assign sum            = prod + DistHalf;
  assign dist_o         = sum[DistShift +: DistW];
  assign out_of_range_o = (dist_o == '0) || (dist_o > max_dist_i);

endmodule

// File: sv/uer_seq.sv
// ----------------------------------------------------------------------------
// uer_seq
// Measurement sequencer: trigger, echo rise wait, echo high count, result.
// ----------------------------------------------------------------------------
module uer_seq import uer_pkg::*; #(
  parameter int NumSensors = NumSensorsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_req_t  req_i,
  input  cfg_t     cfg_i,
  output out_req_t res_o
);

  phase_e            phase_q, phase_d, ph;
  logic [SelW-1:0]   act_q, act_d, act;
  logic [CntW-1:0]   wait_q, wait_d, wc, wc_inc;
  logic [CntW-1:0]   echo_q, echo_d, ec;
  logic              start_ok;
  logic [7:0]        echo_ext;
  logic [7:0]        trig_ext;
  logic              echo_hi;
  logic [TrigW-1:0]  tlen;
  logic [CntW-1:0]   hlim;
  logic [DistW-1:0]  dist_cm;
  logic              out_of_range;
  status_e           st;
  logic              done;

  uer_dist u_dist (
    .ticks_i        (ec),
    .max_dist_i     (cfg_i.max_distance),
    .dist_o         (dist_cm),
    .out_of_range_o (out_of_range)
  );

  always_comb begin
    start_ok = (phase_q == PhIdle) && req_i.start_req &&
               ({1'b0, req_i.sensor_sel} < 4'(NumSensors));
    act      = start_ok ? req_i.sensor_sel : act_q;
    ph       = start_ok ? PhTrig : phase_q;
    wc       = start_ok ? '0 : wait_q;
    ec       = start_ok ? '0 : echo_q;
    wc_inc   = wc + 16'd1;
    echo_ext = 8'(req_i.echo_lines);
    echo_hi  = echo_ext[act];
    trig_ext = 8'd1 << act;
    tlen     = (cfg_i.trigger_ticks == '0) ? 8'd1 : cfg_i.trigger_ticks;
    hlim     = (cfg_i.high_timeout == '0) ? 16'd1 : cfg_i.high_timeout;

    phase_d = ph;
    act_d   = act;
    wait_d  = wc;
    echo_d  = ec;
    done    = 1'b0;
    st      = StOk;
    res_o   = '0;

    unique case (ph)
      PhTrig: begin
        res_o.trigger_lines = trig_ext[LineW-1:0];
        if (wc_inc >= CntW'(tlen)) begin
          phase_d = PhRise;
          wait_d  = '0;
        end else begin
          wait_d = wc_inc;
        end
      end
      PhRise: begin
        if (echo_hi) begin
          phase_d = PhHigh;
          echo_d  = 16'd1;
        end else if (wc >= cfg_i.rise_timeout) begin
          done = 1'b1;
          st   = StNoRise;
        end else begin
          wait_d = wc_inc;
        end
      end
      PhHigh: begin
        if (echo_hi) begin
          if (ec >= hlim) begin
            done = 1'b1;
            st   = StTooLong;
          end else begin
            echo_d = ec + 16'd1;
          end
        end else begin
          done = 1'b1;
          if (out_of_range) begin
            st = StRange;
          end else begin
            res_o.distance_cm = dist_cm;
          end
        end
      end
      PhIdle: ;
      default: ;
    endcase

    if (done) begin
      phase_d          = PhIdle;
      wait_d           = '0;
      echo_d           = '0;
      res_o.done_res   = 1'b1;
      res_o.sensor_out = act;
      res_o.status     = st;
    end
    res_o.busy_res = (phase_d != PhIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      act_q   <= '0;
      wait_q  <= '0;
      echo_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      act_q   <= act_d;
      wait_q  <= wait_d;
      echo_q  <= echo_d;
    end
  end

endmodule

// File: sv/uer_checker.sv
// ----------------------------------------------------------------------------
// uer_checker
// Port-level checks on the echo ranger result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_assert.svh"

module uer_checker import uer_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  out_req_t            out_req_o
);

  `UER_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_req_o), "stalled result request changed")

  `UER_ASSERT_NOW(a_done_idle, out_valid_o && out_req_o.done_res,
    !out_req_o.busy_res && out_req_o.trigger_lines == '0,
    "finishing tick still busy or triggering")

  `UER_ASSERT_NOW(a_quiet_fields, out_valid_o && !out_req_o.done_res,
    out_req_o.sensor_out == '0 && out_req_o.distance_cm == '0 &&
    out_req_o.status == StOk, "result fields set without done")

  `UER_ASSERT_NOW(a_trig_busy, out_valid_o && out_req_o.trigger_lines != '0,
    $onehot(out_req_o.trigger_lines) && out_req_o.busy_res,
    "trigger drive not one-hot or not busy")

  `UER_ASSERT_NOW(a_ok_dist, out_valid_o && out_req_o.done_res &&
    out_req_o.status == StOk, out_req_o.distance_cm != '0,
    "good result with zero distance")

endmodule

bind ultrasonic_echo_ranger uer_checker u_checker (.*);
